[design/aasched_pkg.sv]
`default_nettype none

package aasched_pkg;

  // Default sizing of the operation list and of the latency registers.
  localparam int unsigned DEF_MAX_OPS   = 16;
  localparam int unsigned DEF_LAT_WIDTH = 4;

  // Fixed field widths.
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned OUT_W     = 8;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_KINDS = 6;

  // Operation kinds. Codes six and seven carry no meaning.
  typedef enum logic [KIND_W-1:0] {
    KIND_INIT  = 3'd0,
    KIND_LOAD  = 3'd1,
    KIND_STORE = 3'd2,
    KIND_FADD  = 3'd3,
    KIND_FMUL  = 3'd4,
    KIND_MAC   = 3'd5
  } op_kind_e;

  // Latency register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LAT_INIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_LOAD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_STORE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_FADD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_FMUL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_MAC   = 3'd5;

  // One result of the schedule, as handed from the core to the ports.
  typedef struct packed {
    logic [IDX_OUT_W-1:0] op_index;
    logic [OUT_W-1:0]     asap_start;
    logic [OUT_W-1:0]     alap_start;
    logic [OUT_W-1:0]     slack_cycles;
    logic [OUT_W-1:0]     pipe_depth;
    logic                 overflow;
    logic                 last_result;
  } result_t;

endpackage

`default_nettype wire

[design/aasched_ram.sv]
`default_nettype none

module aasched_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/aasched_latreg.sv]
`default_nettype none

module aasched_latreg #(
  parameter int unsigned LAT_WIDTH = aasched_pkg::DEF_LAT_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [aasched_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LAT_WIDTH-1:0]              cfg_wdata_i,
  input  wire logic [aasched_pkg::KIND_W-1:0]    kind_i,
  output logic      [LAT_WIDTH-1:0]              lat_o
);

  import aasched_pkg::*;

  logic [LAT_WIDTH-1:0] lat_q [NUM_KINDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KINDS; k++) begin
        lat_q[k] <= LAT_WIDTH'(1);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LAT_INIT:  lat_q[REG_LAT_INIT]  <= cfg_wdata_i;
        REG_LAT_LOAD:  lat_q[REG_LAT_LOAD]  <= cfg_wdata_i;
        REG_LAT_STORE: lat_q[REG_LAT_STORE] <= cfg_wdata_i;
        REG_LAT_FADD:  lat_q[REG_LAT_FADD]  <= cfg_wdata_i;
        REG_LAT_FMUL:  lat_q[REG_LAT_FMUL]  <= cfg_wdata_i;
        REG_LAT_MAC:   lat_q[REG_LAT_MAC]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Kinds without a register are given the same latency value that reset loads.
  always_comb begin
    unique case (op_kind_e'(kind_i))
      KIND_INIT:  lat_o = lat_q[REG_LAT_INIT];
      KIND_LOAD:  lat_o = lat_q[REG_LAT_LOAD];
      KIND_STORE: lat_o = lat_q[REG_LAT_STORE];
      KIND_FADD:  lat_o = lat_q[REG_LAT_FADD];
      KIND_FMUL:  lat_o = lat_q[REG_LAT_FMUL];
      KIND_MAC:   lat_o = lat_q[REG_LAT_MAC];
      default:    lat_o = LAT_WIDTH'(1);
    endcase
  end

endmodule

`default_nettype wire

[design/aasched_core.sv]
`default_nettype none

module aasched_core #(
  parameter int unsigned MAX_OPS   = aasched_pkg::DEF_MAX_OPS,
  parameter int unsigned LAT_WIDTH = aasched_pkg::DEF_LAT_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [aasched_pkg::MASK_W-1:0] pred_mask_i,
  input  wire logic                           last_op_i,
  input  wire logic [LAT_WIDTH-1:0]           op_lat_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output aasched_pkg::result_t                res_o
);

  import aasched_pkg::*;

  localparam int unsigned IDX_W    = $clog2(MAX_OPS);
  localparam int unsigned CNT_W    = $clog2(MAX_OPS + 1);
  localparam int unsigned TIME_MAX = MAX_OPS * ((1 << LAT_WIDTH) - 1);
  localparam int unsigned TIME_W   = $clog2(TIME_MAX + 1);

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_FHEAD  = 4'd1;
  localparam logic [3:0] ST_FLATCH = 4'd2;
  localparam logic [3:0] ST_FSCAN  = 4'd3;
  localparam logic [3:0] ST_FWB    = 4'd4;
  localparam logic [3:0] ST_BHEAD  = 4'd5;
  localparam logic [3:0] ST_BLATCH = 4'd6;
  localparam logic [3:0] ST_BSCAN  = 4'd7;
  localparam logic [3:0] ST_BWB    = 4'd8;
  localparam logic [3:0] ST_ORD    = 4'd9;
  localparam logic [3:0] ST_OLOAD  = 4'd10;
  localparam logic [3:0] ST_OWAIT  = 4'd11;

  function automatic logic [OUT_W-1:0] sat8(input logic [TIME_W-1:0] v);
    if (32'(v) > 32'd255) begin
      return 8'hFF;
    end
    return OUT_W'(v);
  endfunction

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [CNT_W-1:0]  pj_q, pj_d;
  logic              pend_q, pend_d;
  logic [MASK_W-1:0] pred_q, pred_d;
  logic [LAT_WIDTH-1:0] lat_i_q, lat_i_d;
  logic [TIME_W-1:0] best_q, best_d;
  logic [TIME_W-1:0] depth_q, depth_d;
  result_t           res_q, res_d;

  // Memory ports.
  logic                 lat_we, pred_we, asap_we, alap_we;
  logic [IDX_W-1:0]     lat_raddr, pred_raddr, asap_raddr, alap_raddr;
  logic [IDX_W-1:0]     wr_addr;
  logic [MASK_W-1:0]    pred_wdata;
  logic [TIME_W-1:0]    time_wdata;
  logic [LAT_WIDTH-1:0] lat_rd;
  logic [MASK_W-1:0]    pred_rd;
  logic [TIME_W-1:0]    asap_rd, alap_rd;

  logic [MASK_W-1:0] keep_mask;
  logic              full;
  logic              last_idx;
  logic              fscan_issue, bscan_issue;
  logic [3:0]        fsel, bsel;
  logic [TIME_W-1:0] fin_j, fin_i, lat_i_ext, lim, slack;

  aasched_ram #(.WIDTH(LAT_WIDTH), .DEPTH(MAX_OPS)) u_lat_ram (
    .clk_i   (clk_i),
    .we_i    (lat_we),
    .waddr_i (wr_addr),
    .wdata_i (op_lat_i),
    .raddr_i (lat_raddr),
    .rdata_o (lat_rd)
  );

  aasched_ram #(.WIDTH(MASK_W), .DEPTH(MAX_OPS)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (pred_we),
    .waddr_i (wr_addr),
    .wdata_i (pred_wdata),
    .raddr_i (pred_raddr),
    .rdata_o (pred_rd)
  );

  aasched_ram #(.WIDTH(TIME_W), .DEPTH(MAX_OPS)) u_asap_ram (
    .clk_i   (clk_i),
    .we_i    (asap_we),
    .waddr_i (wr_addr),
    .wdata_i (time_wdata),
    .raddr_i (asap_raddr),
    .rdata_o (asap_rd)
  );

  aasched_ram #(.WIDTH(TIME_W), .DEPTH(MAX_OPS)) u_alap_ram (
    .clk_i   (clk_i),
    .we_i    (alap_we),
    .waddr_i (wr_addr),
    .wdata_i (time_wdata),
    .raddr_i (alap_raddr),
    .rdata_o (alap_rd)
  );

  always_comb begin
    // An operation may only depend on those before it.
    for (int b = 0; b < MASK_W; b++) begin
      keep_mask[b] = (b < int'(cnt_q));
    end
    full        = (cnt_q == CNT_W'(MAX_OPS));
    last_idx    = (i_q == (cnt_q - CNT_W'(1)));
    fscan_issue = (j_q < i_q) && (int'(j_q) < MASK_W);
    bscan_issue = (j_q < cnt_q) && (int'(i_q) < MASK_W);
    fsel        = 4'(pj_q);
    bsel        = 4'(i_q);
    lat_i_ext   = TIME_W'(lat_i_q);
    fin_j       = asap_rd + TIME_W'(lat_rd);
    fin_i       = best_q + lat_i_ext;
    lim         = (alap_rd >= lat_i_ext) ? (alap_rd - lat_i_ext) : '0;
    slack       = (alap_rd >= asap_rd) ? (alap_rd - asap_rd) : '0;

    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    i_d     = i_q;
    j_d     = j_q;
    pj_d    = pj_q;
    pend_d  = pend_q;
    pred_d  = pred_q;
    lat_i_d = lat_i_q;
    best_d  = best_q;
    depth_d = depth_q;
    res_d   = res_q;

    lat_we     = 1'b0;
    pred_we    = 1'b0;
    asap_we    = 1'b0;
    alap_we    = 1'b0;
    wr_addr    = i_q[IDX_W-1:0];
    pred_wdata = pred_mask_i & keep_mask;
    time_wdata = best_q;
    lat_raddr  = i_q[IDX_W-1:0];
    pred_raddr = i_q[IDX_W-1:0];
    asap_raddr = i_q[IDX_W-1:0];
    alap_raddr = i_q[IDX_W-1:0];

    unique case (state_q)
      ST_LOAD: begin
        wr_addr = cnt_q[IDX_W-1:0];
        if (in_valid_i) begin
          if (!full) begin
            lat_we  = 1'b1;
            pred_we = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_op_i) begin
            i_d     = '0;
            depth_d = '0;
            state_d = ST_FHEAD;
          end
        end
      end
      ST_FHEAD: begin
        state_d = ST_FLATCH;
      end
      ST_FLATCH: begin
        pred_d  = pred_rd;
        lat_i_d = lat_rd;
        best_d  = '0;
        j_d     = '0;
        pend_d  = 1'b0;
        state_d = ST_FSCAN;
      end
      ST_FSCAN: begin
        lat_raddr  = j_q[IDX_W-1:0];
        asap_raddr = j_q[IDX_W-1:0];
        pend_d     = fscan_issue;
        pj_d       = j_q;
        if (fscan_issue) begin
          j_d = j_q + CNT_W'(1);
        end
        if (pend_q && pred_q[fsel] && (fin_j > best_q)) begin
          best_d = fin_j;
        end
        if (!fscan_issue && !pend_q) begin
          state_d = ST_FWB;
        end
      end
      ST_FWB: begin
        asap_we = 1'b1;
        if (fin_i > depth_q) begin
          depth_d = fin_i;
        end
        if (last_idx) begin
          state_d = ST_BHEAD;
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = ST_FHEAD;
        end
      end
      ST_BHEAD: begin
        state_d = ST_BLATCH;
      end
      ST_BLATCH: begin
        lat_i_d = lat_rd;
        best_d  = depth_q - TIME_W'(lat_rd);
        j_d     = i_q + CNT_W'(1);
        pend_d  = 1'b0;
        state_d = ST_BSCAN;
      end
      ST_BSCAN: begin
        pred_raddr = j_q[IDX_W-1:0];
        alap_raddr = j_q[IDX_W-1:0];
        pend_d     = bscan_issue;
        if (bscan_issue) begin
          j_d = j_q + CNT_W'(1);
        end
        if (pend_q && pred_rd[bsel] && (lim < best_q)) begin
          best_d = lim;
        end
        if (!bscan_issue && !pend_q) begin
          state_d = ST_BWB;
        end
      end
      ST_BWB: begin
        alap_we = 1'b1;
        if (i_q == '0) begin
          state_d = ST_ORD;
        end else begin
          i_d     = i_q - CNT_W'(1);
          state_d = ST_BHEAD;
        end
      end
      ST_ORD: begin
        state_d = ST_OLOAD;
      end
      ST_OLOAD: begin
        res_d.op_index     = IDX_OUT_W'(i_q);
        res_d.asap_start   = sat8(asap_rd);
        res_d.alap_start   = sat8(alap_rd);
        res_d.slack_cycles = sat8(slack);
        res_d.pipe_depth   = sat8(depth_q);
        res_d.overflow     = ovf_q;
        res_d.last_result  = last_idx;
        state_d            = ST_OWAIT;
      end
      ST_OWAIT: begin
        // Fetch the next entry ahead, so it is ready right after the transfer.
        asap_raddr = IDX_W'(i_q + CNT_W'(1));
        alap_raddr = IDX_W'(i_q + CNT_W'(1));
        if (out_ready_i) begin
          if (last_idx) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = ST_OLOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pj_q    <= pj_d;
    pred_q  <= pred_d;
    lat_i_q <= lat_i_d;
    best_q  <= best_d;
    depth_q <= depth_d;
    res_q   <= res_d;
  end

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_OWAIT);
  assign res_o       = res_q;

endmodule

`default_nettype wire

[design/asap_alap_slack_scheduler_top.sv]
`default_nettype none

// Channel  Handshake               Payload
// -------  ----------------------  ---------------------------------------------------
// in       in_valid_i/in_ready_o   op_kind_i, pred_mask_i, last_op_i
// out      out_valid_o/out_ready_i op_index_o, asap_start_o, alap_start_o,
//                                  slack_cycles_o, pipe_depth_o, overflow_o,
//                                  last_result_o
// cfg      cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
// Loading accepts one input transfer per cycle. After the last operation the forward pass
// scans, for each operation i, the k = min(i, 16) operations before it; the backward pass
// likewise from the last index down, with k = n - 1 - i (none from index 16 up). A set-up
// state follows, then per result a load and a wait state, held through any output stall.
// No input is taken from the last operation until the final result transfer. Reset sets
// every latency register to one and empties the list; only entries of this run are used.
module asap_alap_slack_scheduler_top #(
  parameter int unsigned MAX_OPS   = aasched_pkg::DEF_MAX_OPS,
  parameter int unsigned LAT_WIDTH = aasched_pkg::DEF_LAT_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Operation list input.
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [aasched_pkg::KIND_W-1:0]    op_kind_i,
  input  wire logic [aasched_pkg::MASK_W-1:0]    pred_mask_i,
  input  wire logic                              last_op_i,
  // Schedule results.
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [aasched_pkg::IDX_OUT_W-1:0]      op_index_o,
  output logic [aasched_pkg::OUT_W-1:0]          asap_start_o,
  output logic [aasched_pkg::OUT_W-1:0]          alap_start_o,
  output logic [aasched_pkg::OUT_W-1:0]          slack_cycles_o,
  output logic [aasched_pkg::OUT_W-1:0]          pipe_depth_o,
  output logic                                   overflow_o,
  output logic                                   last_result_o,
  // Latency register writes.
  input  wire logic                              cfg_we_i,
  input  wire logic [aasched_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LAT_WIDTH-1:0]              cfg_wdata_i
);

  import aasched_pkg::*;

  logic [LAT_WIDTH-1:0] op_lat;
  result_t              res;

  // The latency registers translate the kind of the incoming operation into its
  // latency, which the core stores alongside the predecessor mask.
  aasched_latreg #(
    .LAT_WIDTH (LAT_WIDTH)
  ) u_latreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (op_kind_i),
    .lat_o       (op_lat)
  );

  // The core holds the list in four memories and walks it forwards for the
  // earliest start times and backwards for the latest ones.
  aasched_core #(
    .MAX_OPS   (MAX_OPS),
    .LAT_WIDTH (LAT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pred_mask_i (pred_mask_i),
    .last_op_i   (last_op_i),
    .op_lat_i    (op_lat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign op_index_o     = res.op_index;
  assign asap_start_o   = res.asap_start;
  assign alap_start_o   = res.alap_start;
  assign slack_cycles_o = res.slack_cycles;
  assign pipe_depth_o   = res.pipe_depth;
  assign overflow_o     = res.overflow;
  assign last_result_o  = res.last_result;

endmodule

`default_nettype wire
